// ----- rtl/descriptor_free_list_allocator_defines.svh -----
// Assertion macros for the descriptor free-list allocator.
// Depends on nothing; taken in by the top level with `include.
`ifndef DESCRIPTOR_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define DESCRIPTOR_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define DFLA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define DFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dfla_pkg.sv -----
// Shared widths, codes and defaults of the descriptor free-list allocator.
// Depends on nothing; used by the channel interfaces and the top level.
package dfla_pkg;

    localparam int HANDLE_W      = 64;
    localparam int STEP_W        = 16;
    localparam int COUNT_W       = 11;
    localparam int SLOT_OUT_W    = 10;
    localparam int STATUS_W      = 3;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int SLOTS_DEFAULT = 1024;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RELOAD = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_MISMATCH = 3'd2,
        STAT_RANGE    = 3'd3,
        STAT_FULL     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPU_BASE   = 8'd0,
        CFG_GPU_BASE   = 8'd1,
        CFG_STEP       = 8'd2,
        CFG_SLOT_COUNT = 8'd3
    } t_cfg_reg;

endpackage

// ----- rtl/dfla_if.sv -----
// Valid/ready channel interfaces: request, response and register write.
// Depends on dfla_pkg for field widths and codes.
interface dfla_req_if
    import dfla_pkg::*;
();
    logic                valid;
    logic                ready;
    t_op                 operation;
    logic [HANDLE_W-1:0] cpu_handle_in;
    logic [HANDLE_W-1:0] gpu_handle_in;

    modport source (output valid, output operation, output cpu_handle_in,
                    output gpu_handle_in, input ready);
    modport sink   (input valid, input operation, input cpu_handle_in,
                    input gpu_handle_in, output ready);
endinterface

interface dfla_rsp_if
    import dfla_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [HANDLE_W-1:0]   cpu_handle_out;
    logic [HANDLE_W-1:0]   gpu_handle_out;
    logic [SLOT_OUT_W-1:0] slot_index;
    t_status               status;

    modport source (output valid, output cpu_handle_out, output gpu_handle_out,
                    output slot_index, output status, input ready);
    modport sink   (input valid, input cpu_handle_out, input gpu_handle_out,
                    input slot_index, input status, output ready);
endinterface

interface dfla_cfg_if
    import dfla_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- rtl/descriptor_free_list_allocator.sv -----
// Descriptor free-list allocator: LIFO stack of slot indices in one SRAM.
// Allocate pops, scales and rebases a slot; clear goes straight to the response
// register; free runs a 64-step serial divide of both handle offsets and a check;
// reload does one stack write per cycle. One request is in flight at a time.
// Reset (synchronous, active low) empties the list and restores the registers.
`include "descriptor_free_list_allocator_defines.svh"

module descriptor_free_list_allocator
    import dfla_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfla_cfg_if.sink   i_cfg,
    dfla_req_if.sink   i_req,
    dfla_rsp_if.source o_rsp
);

    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W    = $clog2(SLOTS + 1);
    localparam int CMP_W     = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
    localparam int PROD_W    = IDX_W + STEP_W;
    localparam int DIV_CNT_W = $clog2(HANDLE_W);
    localparam int LANES     = 2;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(HANDLE_W - 1);
    localparam logic [FILL_W-1:0]    FILL_MAX = FILL_W'(SLOTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ADD  = 7'b0010000,
        S_FILL = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    // Configuration registers
    logic [HANDLE_W-1:0] r_cpu_base;
    logic [HANDLE_W-1:0] r_gpu_base;
    logic [STEP_W-1:0]   r_step;
    logic [COUNT_W-1:0]  r_slot_count;

    // Control state
    t_state              r_state;
    t_state              n_state;
    logic [FILL_W-1:0]   r_fill;
    logic [IDX_W-1:0]    r_sweep;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Stack memory
    logic [IDX_W-1:0]    r_stack [SLOTS];
    logic [IDX_W-1:0]    r_rd_data;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    // Serial divider lanes: 0 for the CPU handle, 1 for the GPU handle
    logic [STEP_W-1:0]   r_rem [LANES];
    logic [HANDLE_W-1:0] r_quo [LANES];
    logic [STEP_W-1:0]   rem_nx [LANES];
    logic [HANDLE_W-1:0] quo_nx [LANES];

    // Datapath
    logic [PROD_W-1:0]     r_prod;
    logic [HANDLE_W-1:0]   r_res_cpu;
    logic [HANDLE_W-1:0]   r_res_gpu;
    logic [SLOT_OUT_W-1:0] r_res_slot;
    t_status               r_res_status;

    // Response register
    logic                  r_out_valid;
    logic [HANDLE_W-1:0]   r_out_cpu;
    logic [HANDLE_W-1:0]   r_out_gpu;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    t_status               r_out_status;

    logic                req_fire;
    logic                out_load;
    logic [FILL_W-1:0]   eff_count;
    t_status             chk_status;
    logic                push_ok;
    logic                sweep_last;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Clamp the configured count to the stack depth
    assign eff_count = (CMP_W'(r_slot_count) > CMP_W'(SLOTS)) ? FILL_MAX
                                                              : FILL_W'(r_slot_count);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_base   <= '0;
            r_gpu_base   <= '0;
            r_step       <= STEP_RESET;
            r_slot_count <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                CFG_CPU_BASE:   r_cpu_base   <= i_cfg.wr_data;
                CFG_GPU_BASE:   r_gpu_base   <= i_cfg.wr_data;
                CFG_STEP:       r_step       <= i_cfg.wr_data[STEP_W-1:0];
                CFG_SLOT_COUNT: r_slot_count <= i_cfg.wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // One restoring-division step per lane
    for (genvar g = 0; g < LANES; g++) begin : g_div
        logic [STEP_W:0] rem_sh;
        logic [STEP_W:0] rem_sub;
        logic            ge;

        assign rem_sh    = {r_rem[g], r_quo[g][HANDLE_W-1]};
        assign rem_sub   = rem_sh - {1'b0, r_step};
        assign ge        = (rem_sh >= {1'b0, r_step});
        assign rem_nx[g] = ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
        assign quo_nx[g] = {r_quo[g][HANDLE_W-2:0], ge};
    end

    // Classify a free once both quotients are in
    always_comb begin
        if (r_quo[0] != r_quo[1]) begin
            chk_status = STAT_MISMATCH;
        end else if (r_quo[0] >= HANDLE_W'(eff_count)) begin
            chk_status = STAT_RANGE;
        end else if (r_fill == FILL_MAX) begin
            chk_status = STAT_FULL;
        end else begin
            chk_status = STAT_OK;
        end
    end

    assign push_ok    = (r_state == S_CHK) && (chk_status == STAT_OK);
    assign sweep_last = (FILL_W'(r_sweep) == (eff_count - FILL_W'(1)));
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    // Stack port control: pop read at accept, pushes from free and reload
    always_comb begin
        mem_re    = req_fire && (i_req.operation == OP_ALLOC) && (r_fill != '0);
        mem_raddr = IDX_W'(r_fill - FILL_W'(1));
        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = IDX_W'(eff_count - FILL_W'(1) - FILL_W'(r_sweep));
        if (r_state == S_FILL) begin
            mem_we = 1'b1;
        end else if (push_ok) begin
            mem_we    = 1'b1;
            mem_waddr = r_fill[IDX_W-1:0];
            mem_wdata = r_quo[0][IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_stack[mem_raddr];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    unique case (i_req.operation)
                        OP_ALLOC:  n_state = (r_fill == '0) ? S_EMIT : S_MUL;
                        OP_FREE:   n_state = (r_step == '0) ? S_EMIT : S_DIV;
                        OP_RELOAD: n_state = (eff_count == '0) ? S_EMIT : S_FILL;
                        OP_CLEAR:  n_state = S_EMIT;
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_DIV:   n_state = (r_div_cnt == DIV_LAST) ? S_CHK : S_DIV;
            S_CHK:   n_state = S_EMIT;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_EMIT;
            S_FILL:  n_state = sweep_last ? S_EMIT : S_FILL;
            S_EMIT:  n_state = out_load ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_sweep   <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (req_fire) begin
                r_sweep   <= '0;
                r_div_cnt <= '0;
                if (i_req.operation == OP_CLEAR ||
                    (i_req.operation == OP_RELOAD && eff_count == '0)) begin
                    r_fill <= '0;
                end else if (mem_re) begin
                    r_fill <= r_fill - FILL_W'(1);
                end
            end
            if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            if (r_state == S_FILL) begin
                r_sweep <= r_sweep + IDX_W'(1);
                if (sweep_last) begin
                    r_fill <= eff_count;
                end
            end
            if (push_ok) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    // Datapath: offsets, divide, scale and rebase, result capture
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_res_cpu    <= '0;
            r_res_gpu    <= '0;
            r_res_slot   <= '0;
            r_quo[0]     <= i_req.cpu_handle_in - r_cpu_base;
            r_quo[1]     <= i_req.gpu_handle_in - r_gpu_base;
            r_rem[0]     <= '0;
            r_rem[1]     <= '0;
            if (i_req.operation == OP_ALLOC && r_fill == '0) begin
                r_res_status <= STAT_EMPTY;
            end else if (i_req.operation == OP_FREE && r_step == '0) begin
                r_res_status <= STAT_RANGE;
            end else begin
                r_res_status <= STAT_OK;
            end
        end
        if (r_state == S_DIV) begin
            for (int l = 0; l < LANES; l++) begin
                r_rem[l] <= rem_nx[l];
                r_quo[l] <= quo_nx[l];
            end
        end
        if (r_state == S_CHK) begin
            r_res_status <= chk_status;
            if (chk_status == STAT_OK) begin
                r_res_slot <= SLOT_OUT_W'(r_quo[0]);
            end
        end
        if (r_state == S_MUL) begin
            r_prod     <= PROD_W'(r_rd_data) * PROD_W'(r_step);
            r_res_slot <= SLOT_OUT_W'(r_rd_data);
        end
        if (r_state == S_ADD) begin
            r_res_cpu <= r_cpu_base + HANDLE_W'(r_prod);
            r_res_gpu <= r_gpu_base + HANDLE_W'(r_prod);
        end
    end

    // Response register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cpu    <= r_res_cpu;
            r_out_gpu    <= r_res_gpu;
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.cpu_handle_out = r_out_cpu;
    assign o_rsp.gpu_handle_out = r_out_gpu;
    assign o_rsp.slot_index     = r_out_slot;
    assign o_rsp.status         = r_out_status;

    // Checks
    `DFLA_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX, "fill above depth")
    `DFLA_ASSERT_NEXT(a_push_inc, i_clk, i_rst_n, push_ok, r_fill == $past(r_fill) + FILL_W'(1), "push lost")
    `DFLA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, req_fire, r_state != S_IDLE, "request dropped")

endmodule
